// File: hdl/gns_pkg.sv
// ----------------------------------------------------------------------------
// gns_pkg
// Shared types, field layouts, codes and the generator step function for
// the graph neighbor sampler.
// ----------------------------------------------------------------------------
package gns_pkg;

  // Input kinds (carried on in_tuser)
  localparam logic [1:0] OP_WR_OFF = 2'd0;
  localparam logic [1:0] OP_WR_NBR = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Configuration register indexes
  localparam int         CFG_AW     = 1;
  localparam logic [0:0] REG_FANOUT = 1'b0;
  localparam logic [0:0] REG_SEED   = 1'b1;
  localparam int         CFG_DW     = 32;

  // Register reset values
  localparam logic [5:0]  FANOUT_RESET = 6'd10;
  localparam logic [31:0] SEED_RESET   = 32'd1;

  // Field widths
  localparam int OP_W    = 2;
  localparam int INDEX_W = 13;
  localparam int VALUE_W = 14;
  localparam int NODE_W  = 10;
  localparam int CAP_W   = 6;
  localparam int NBR_W   = 10;
  localparam int SLOT_W  = 13;
  localparam int DEG_W   = 14;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // Remainder unit: one quotient bit per cycle over a 32-bit dividend
  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = 5;

  // Input tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]         pad;
    logic [CAP_W-1:0]   capacity;
    logic [NODE_W-1:0]  node;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } in_data_t;

  // Request into the remainder unit
  typedef struct packed {
    logic              start;
    logic [31:0]       dividend;
    logic [DEG_W-1:0]  divisor;
  } urem_req_t;

  // Response from the remainder unit
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DEG_W-1:0]  rem;
  } urem_rsp_t;

  // One xorshift32 step, shifts 13 / 17 / 5
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

// File: hdl/gns_rng.sv
// ----------------------------------------------------------------------------
// gns_rng
// 32-bit xorshift generator. Loads from the seed register (zero maps to one)
// and advances one step on request.
// ----------------------------------------------------------------------------
module gns_rng (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [31:0] seed,
  input  logic        step,
  output logic [31:0] rnd_nxt
);
  import gns_pkg::*;

  logic [31:0] state_r;

  // Value produced by the next step
  assign rnd_nxt = xorshift32(state_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEED_RESET;
    end else if (load) begin
      state_r <= (seed == 32'd0) ? 32'd1 : seed;
    end else if (step) begin
      state_r <= rnd_nxt;
    end
  end

endmodule

// File: hdl/gns_urem.sv
// ----------------------------------------------------------------------------
// gns_urem
// Iterative restoring remainder: 32-bit dividend modulo a 14-bit divisor,
// one dividend bit per cycle. Result is valid with the done pulse.
// ----------------------------------------------------------------------------
module gns_urem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gns_pkg::urem_req_t   req,
  output gns_pkg::urem_rsp_t   rsp
);
  import gns_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [31:0]       dvd_r;
  logic [DEG_W-1:0]  dsr_r;
  logic [DEG_W-1:0]  rem_r;
  logic [DEG_W:0]    rem_sh;
  logic              fits;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh = {rem_r, dvd_r[31]};
  assign fits   = rem_sh >= {1'b0, dsr_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= fits ? DEG_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DEG_W-1:0];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  // A start always puts the unit to work
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r)
    else $error("remainder unit not busy after start");

  // The result is never flagged while still iterating
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("remainder done while busy");

endmodule

// File: hdl/graph_neighbor_sampler.sv
// ----------------------------------------------------------------------------
// graph_neighbor_sampler
// Compressed-column graph store with per-node neighbor sampling without
// replacement. A shared iterative remainder unit reduces each xorshift draw
// modulo the node degree; a small sequencer rejects repeated slots.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  in_      in   tvalid/tready      tuser: op; tdata: index, value, node, capacity
//  out_     out  tvalid/tready      tdata: neighbor, slot; tlast: last
//  cfg_     in   we (no wait)       addr: register index; wdata: value
//
// A sample reads the offsets (S_RDS, S_RDE, S_DEG), then per draw runs the
// remainder unit (S_DRAW, S_DIV), compares each picked slot (S_SCAN, S_CMP) and
// stores a new pick, then emits each result through S_EPK, S_ENB and S_EOUT.
// The remainder unit (one bit a cycle) dominates.
// Reset clears control, sets fanout to 10 and the generator to 1; the tables
// are not cleared. in_tready is high only while the sequencer is idle; a full
// output register stalls the result path in S_EOUT and with it the next item.
// ----------------------------------------------------------------------------
module graph_neighbor_sampler #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192,
  parameter int MAX_PICKS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input transactions
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gns_pkg::IN_TDATA_W-1:0]    in_tdata,  // index, value, node, capacity
  input  logic [gns_pkg::OP_W-1:0]          in_tuser,  // op
  // result transactions
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gns_pkg::OUT_TDATA_W-1:0]   out_tdata, // neighbor, slot
  output logic                              out_tlast,
  // configuration
  input  logic                              cfg_we,
  input  logic [gns_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [gns_pkg::CFG_DW-1:0]        cfg_wdata
);
  import gns_pkg::*;

  localparam int OA_W = $clog2(MAX_NODES + 1);
  localparam int NA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int PA_W = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
  localparam int PC_W = $clog2(MAX_PICKS + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDS  = 4'd1;
  localparam logic [3:0] S_RDE  = 4'd2;
  localparam logic [3:0] S_DEG  = 4'd3;
  localparam logic [3:0] S_DRAW = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_EPK  = 4'd8;
  localparam logic [3:0] S_ENB  = 4'd9;
  localparam logic [3:0] S_EOUT = 4'd10;

  // Memories
  logic [VALUE_W-1:0] off_mem [MAX_NODES+1];
  logic [NBR_W-1:0]   nb_mem  [MAX_EDGES];
  logic [DEG_W-1:0]   pk_mem  [MAX_PICKS];

  logic [VALUE_W-1:0] off_rd_q;
  logic [NBR_W-1:0]   nb_rd_q;
  logic [DEG_W-1:0]   pk_rd_q;

  logic [3:0]         state_r;
  logic [5:0]         fanout_r;
  logic [NODE_W-1:0]  node_r;
  logic [CAP_W-1:0]   cap_r;
  logic [VALUE_W-1:0] start_r;
  logic [DEG_W-1:0]   deg_r;
  logic               seq_r;
  logic [PC_W-1:0]    fo_r;
  logic [PC_W-1:0]    n_r;
  logic [PC_W-1:0]    i_r;
  logic [PC_W-1:0]    count_r;
  logic [PC_W-1:0]    k_r;
  logic [DEG_W-1:0]   r_r;
  logic [DEG_W-1:0]   slot_r;
  logic               e_ok_r;

  logic               out_valid_r;
  logic [NBR_W-1:0]   out_nb_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_last_r;

  in_data_t           in_d;
  logic               in_acc;
  logic               off_we;
  logic               nb_we;
  logic               pk_we;
  logic [OA_W-1:0]    off_raddr;
  logic [PA_W-1:0]    pk_raddr;
  logic [NA_W-1:0]    nb_raddr;
  logic [DEG_W-1:0]   slot_sel;
  logic [DEG_W:0]     e_sum;
  logic               out_free;
  logic               emit_last;
  logic [DEG_W-1:0]   deg_c;
  logic [31:0]        fo32;
  logic [31:0]        cap32;
  logic [31:0]        n32;
  logic               seq_c;
  logic [31:0]        rnd_nxt;
  urem_req_t          ureq;
  urem_rsp_t          ursp;

  assign in_d      = in_data_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // Table write decode
  assign off_we = in_acc && (in_tuser == OP_WR_OFF) && (32'(in_d.index) < MAX_NODES + 1);
  assign nb_we  = in_acc && (in_tuser == OP_WR_NBR) && (32'(in_d.index) < MAX_EDGES);
  assign pk_we  = (state_r == S_SCAN) && (k_r == count_r);

  // Read addresses; the pick read holds on the emitted entry through the emit steps
  assign off_raddr = (state_r == S_RDS) ? OA_W'(node_r) : OA_W'(node_r) + OA_W'(1);
  assign pk_raddr  = (state_r inside {S_EPK, S_ENB, S_EOUT}) ? i_r[PA_W-1:0] :
                                                               k_r[PA_W-1:0];
  assign slot_sel  = seq_r ? DEG_W'(i_r) : pk_rd_q;
  assign e_sum     = {1'b0, start_r} + {1'b0, slot_sel};
  assign nb_raddr  = NA_W'(e_sum);

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[OA_W'(in_d.index)] <= in_d.value;
    end
    off_rd_q <= off_mem[off_raddr];
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[NA_W'(in_d.index)] <= in_d.value[NBR_W-1:0];
    end
    nb_rd_q <= nb_mem[nb_raddr];
  end

  always_ff @(posedge clk) begin
    if (pk_we) begin
      pk_mem[count_r[PA_W-1:0]] <= r_r;
    end
    pk_rd_q <= pk_mem[pk_raddr];
  end

  // Degree, saturated fanout and result count
  always_comb begin
    deg_c = off_rd_q - start_r;
    fo32  = (32'(fanout_r) > MAX_PICKS) ? 32'(MAX_PICKS) : 32'(fanout_r);
    cap32 = 32'(cap_r);
    seq_c = 32'(deg_c) <= fo32;
    if (seq_c) begin
      n32 = (32'(deg_c) < cap32) ? 32'(deg_c) : cap32;
    end else begin
      n32 = (fo32 < cap32) ? fo32 : cap32;
    end
  end

  // Shared generator and remainder unit
  assign ureq.start    = (state_r == S_DRAW);
  assign ureq.dividend = rnd_nxt;
  assign ureq.divisor  = deg_r;

  gns_rng u_rng (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (cfg_we && (cfg_addr == REG_SEED)),
    .seed    (cfg_wdata),
    .step    (ureq.start),
    .rnd_nxt (rnd_nxt)
  );

  gns_urem u_urem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ureq),
    .rsp   (ursp)
  );

  // Fanout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fanout_r <= FANOUT_RESET;
    end else if (cfg_we && (cfg_addr == REG_FANOUT)) begin
      fanout_r <= cfg_wdata[5:0];
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign emit_last = (i_r + PC_W'(1)) == n_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser == OP_SAMPLE) && (32'(in_d.node) < MAX_NODES)
              && (in_d.capacity != '0)) begin
            state_r <= S_RDS;
          end
        end
        S_RDS: state_r <= S_RDE;
        S_RDE: state_r <= S_DEG;
        S_DEG: begin
          if (off_rd_q <= start_r) begin
            state_r <= S_IDLE;
          end else if (!seq_c && (fo32 == 32'd0)) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= seq_c ? S_EPK : S_DRAW;
          end
        end
        S_DRAW: state_r <= S_DIV;
        S_DIV: begin
          if (ursp.done) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (k_r == count_r) begin
            state_r <= ((count_r + PC_W'(1)) == fo_r) ? S_EPK : S_DRAW;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: state_r <= (pk_rd_q == r_r) ? S_DRAW : S_SCAN;
        S_EPK: state_r <= S_ENB;
        S_ENB: state_r <= S_EOUT;
        S_EOUT: begin
          if (out_free) begin
            state_r <= emit_last ? S_IDLE : S_EPK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        node_r <= in_d.node;
        cap_r  <= in_d.capacity;
      end
      S_RDE: start_r <= off_rd_q;
      S_DEG: begin
        deg_r   <= deg_c;
        seq_r   <= seq_c;
        fo_r    <= PC_W'(fo32);
        n_r     <= PC_W'(n32);
        i_r     <= '0;
        count_r <= '0;
      end
      S_DIV: begin
        r_r <= ursp.rem;
        k_r <= '0;
      end
      S_SCAN: begin
        if (k_r == count_r) begin
          count_r <= count_r + PC_W'(1);
          i_r     <= '0;
        end
      end
      S_CMP: k_r <= k_r + PC_W'(1);
      S_ENB: begin
        slot_r <= slot_sel;
        e_ok_r <= 32'(e_sum) < MAX_EDGES;
      end
      S_EOUT: begin
        if (out_free) begin
          i_r <= i_r + PC_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EOUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EOUT) && out_free) begin
      out_nb_r   <= e_ok_r ? nb_rd_q : '0;
      out_slot_r <= slot_r[SLOT_W-1:0];
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_slot_r, out_nb_r};
  assign out_tlast  = out_last_r;

  // The remainder unit only runs while a draw is in progress
  a_urem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ursp.busy)
    else $error("remainder unit busy while idle");

  // The picked list never reaches the fanout during a scan
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (count_r < fo_r))
    else $error("picked count overran fanout");

  // A new result only comes from the emit step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EOUT))
    else $error("result loaded outside emit step");

endmodule

// File: tb/gns_checker.sv
// ----------------------------------------------------------------------------
// gns_checker
// Watches the item, result and register ports of the neighbor sampler and
// keeps its own copy of the graph tables, fanout and generator. Every
// accepted sample transaction is expanded into the neighbors it must produce.
// Each result transaction is compared field by field against the oldest
// neighbor still due. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module gns_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [gns_pkg::IN_TDATA_W-1:0]  in_tdata,   // index, value, node, capacity
  input  logic [gns_pkg::OP_W-1:0]        in_tuser,   // op
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [gns_pkg::OUT_TDATA_W-1:0] out_tdata,  // neighbor, slot
  input  logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [gns_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [gns_pkg::CFG_DW-1:0]      cfg_wdata,
  output int                              mismatches,
  output int                              due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import gns_pkg::*;

  localparam int NODE_CNT  = 1024;
  localparam int EDGE_CNT  = 8192;
  localparam int PICK_CNT  = 32;
  localparam int SHOW_MAX  = 100;

  typedef struct packed {
    logic [NBR_W-1:0]  neighbor;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } pick_t;

  // mirrored block state
  logic [VALUE_W-1:0] offsets   [0:NODE_CNT];
  logic [NBR_W-1:0]   neighbors [0:EDGE_CNT-1];
  int unsigned        drawn     [0:PICK_CNT-1];
  logic [31:0]        gen_state;
  logic [5:0]         fanout_q;

  pick_t due_neighbors[$];

  initial begin
    mismatches = 0;
    due_count  = 0;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= SHOW_MAX) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // one xorshift step, shifts 13 / 17 / 5
  function automatic logic [31:0] advance_gen(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic pick_t make_pick(input int unsigned base, input int unsigned slot,
                                      input bit is_last);
    pick_t p;
    int unsigned e;
    e = base + slot;
    // edges past the table read as node zero
    p.neighbor = (e < EDGE_CNT) ? neighbors[e] : '0;
    p.slot     = slot[SLOT_W-1:0];
    p.last     = is_last;
    return p;
  endfunction

  // queue every neighbor a sample of this node has to produce
  task automatic draw_neighbors(input int unsigned node, input int unsigned cap);
    int unsigned base, stop, deg, fo, n, taken, r;
    bit dup;
    if (cap == 0) return;
    base = offsets[node];
    stop = offsets[node + 1];
    if (stop <= base) return;
    deg = stop - base;
    fo  = (fanout_q > PICK_CNT) ? PICK_CNT : fanout_q;
    if (deg <= fo) begin
      // small list: every slot in order, up to the capacity
      n = (deg < cap) ? deg : cap;
      for (int unsigned i = 0; i < n; i++)
        due_neighbors.push_back(make_pick(base, i, i + 1 == n));
    end else begin
      // rejection draws always run to the full fanout
      taken = 0;
      while (taken < fo) begin
        gen_state = advance_gen(gen_state);
        r = gen_state % deg;
        dup = 1'b0;
        for (int unsigned k = 0; k < taken; k++)
          if (drawn[k] == r) dup = 1'b1;
        if (!dup) begin
          drawn[taken] = r;
          taken++;
        end
      end
      n = (fo < cap) ? fo : cap;
      for (int unsigned i = 0; i < n; i++)
        due_neighbors.push_back(make_pick(base, drawn[i], i + 1 == n));
    end
  endtask

  always @(posedge clk) begin
    pick_t got, want;
    in_data_t item;
    if (!rst_n) begin
      fanout_q  = FANOUT_RESET;
      gen_state = SEED_RESET;
      due_neighbors.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_FANOUT: fanout_q = cfg_wdata[5:0];
          REG_SEED:   gen_state = (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
          default: ;
        endcase
      end

      // result transaction against oldest due neighbor
      if (out_tvalid && out_tready) begin
        got.neighbor = out_tdata[NBR_W-1:0];
        got.slot     = out_tdata[NBR_W+SLOT_W-1:NBR_W];
        got.last     = out_tlast;
        if (due_neighbors.size() == 0) begin
          flag_mismatch($sformatf("result with nothing due: neighbor %0d slot %0d last %0b",
                                  got.neighbor, got.slot, got.last));
        end else begin
          want = due_neighbors.pop_front();
          if (got.neighbor !== want.neighbor)
            flag_mismatch($sformatf("neighbor %0d, want %0d", got.neighbor, want.neighbor));
          if (got.slot !== want.slot)
            flag_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
          if (got.last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        end
      end

      // item transaction
      if (in_tvalid && in_tready) begin
        item = in_data_t'(in_tdata);
        case (in_tuser)
          OP_WR_OFF: if (item.index <= NODE_CNT) offsets[item.index] = item.value;
          OP_WR_NBR: if (item.index < EDGE_CNT) neighbors[item.index] = item.value[NBR_W-1:0];
          OP_SAMPLE: draw_neighbors(item.node, item.capacity);
          default: ;
        endcase
      end
    end
    due_count = due_neighbors.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the graph neighbor sampler. Loads part of the
// neighbor table, runs a directed pass over list shapes and capacities, then
// random graph builds and samples under several fanout and seed settings,
// with random stalls on both channels in the earlier settings. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gns_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int OFF_ENTRIES  = 1025;
  localparam int EDGE_ENTRIES = 8192;
  localparam int LOW_REGION   = 64;     // edges 0..63 preloaded
  localparam int TOP_REGION   = 8176;   // edges 8176..8191 preloaded
  localparam int SETTLE       = 100;
  localparam int RUN_LIMIT    = 20000000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // index, value, node, capacity
  logic [OP_W-1:0]        in_tuser   = '0;   // op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // neighbor, slot
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr   = '0;
  logic [CFG_DW-1:0]      cfg_wdata  = '0;

  int          mismatches;
  int          due_count;
  int          send_gap    = 35;
  int          recv_gap    = 51;
  int          cur_fanout  = 10;
  int unsigned cycle_cnt   = 0;

  // what has been written so far, so no unwritten entry is ever read
  bit                 off_known [0:OFF_ENTRIES-1];
  logic [VALUE_W-1:0] off_val   [0:OFF_ENTRIES-1];
  bit                 nbr_known [0:EDGE_ENTRIES-1];
  int                 built_nodes[$];

  always #2 clk = ~clk;

  graph_neighbor_sampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  gns_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .due_count  (due_count)
  );

  // result side backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_gap);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("FAIL graph_neighbor_sampler");
      $finish;
    end
  end

  // one item transaction; valid stays high between back-to-back items
  task automatic send_txn(input logic [OP_W-1:0] op, input int unsigned idx,
                          input int unsigned val, input int unsigned nd,
                          input int unsigned cap);
    in_data_t d;
    bit took;
    d          = '0;
    d.index    = INDEX_W'(idx);
    d.value    = VALUE_W'(val);
    d.node     = NODE_W'(nd);
    d.capacity = CAP_W'(cap);
    while ($urandom_range(99) < send_gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    // ready is sampled mid-cycle, where it is settled
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    if (op == OP_WR_OFF && idx < OFF_ENTRIES) begin
      off_known[idx] = 1'b1;
      off_val[idx]   = VALUE_W'(val);
    end
    if (op == OP_WR_NBR && idx < EDGE_ENTRIES) nbr_known[idx] = 1'b1;
  endtask

  // stop sending, let every due result out, then let the block settle
  task automatic await_drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_regs(input int fo, input logic [31:0] sd);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FANOUT;
    cfg_wdata <= CFG_DW'(fo);
    @(posedge clk);
    cfg_addr  <= REG_SEED;
    cfg_wdata <= sd;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_fanout = (fo > 32) ? 32 : fo;
  endtask

  // node may be sampled only if every entry it reads has been written
  function automatic bit node_ready(input int n);
    int s, e;
    if (!off_known[n] || !off_known[n + 1]) return 1'b0;
    s = off_val[n];
    e = off_val[n + 1];
    for (int i = s; i < e && i < EDGE_ENTRIES; i++)
      if (!nbr_known[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_capacity();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return 0;
    if (r < 16) return $urandom_range(63, 33);
    if (r < 24) return 32;
    return $urandom_range(12, 1);
  endfunction

  // mostly build-then-sample sequences, the rest noise
  task automatic run_traffic(input int target);
    int issued, pick, sel, n, start, stop, deg, hi;
    issued = 0;
    while (issued < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // lay out one node's list, touch a few edges, sample it
        n   = $urandom_range(1023);
        sel = $urandom_range(99);
        if (sel < 88) begin
          if (sel < 40)      deg = $urandom_range(cur_fanout > 0 ? cur_fanout : 1, 1);
          else if (sel < 80) deg = cur_fanout + $urandom_range(LOW_REGION - cur_fanout, 1);
          else               deg = $urandom_range(LOW_REGION, LOW_REGION / 2);
          start = $urandom_range(LOW_REGION - deg, 0);
          stop  = start + deg;
        end else if (sel < 94) begin
          // list running past the end of the edge table
          start = $urandom_range(EDGE_ENTRIES - 1, TOP_REGION);
          stop  = start + $urandom_range(80, 1);
        end else if (sel < 97) begin
          // offsets beyond the edge table
          start = $urandom_range(16000, EDGE_ENTRIES);
          stop  = start + $urandom_range(300, 1);
        end else begin
          // empty or inverted list
          start = $urandom_range(LOW_REGION - 1, 0);
          stop  = $urandom_range(start, 0);
        end
        send_txn(OP_WR_OFF, n, start, $urandom_range(1023), $urandom_range(63));
        send_txn(OP_WR_OFF, n + 1, stop, $urandom_range(1023), $urandom_range(63));
        if (stop > start && start < EDGE_ENTRIES) begin
          hi = ((stop < EDGE_ENTRIES) ? stop : EDGE_ENTRIES) - 1;
          repeat ($urandom_range(2))
            send_txn(OP_WR_NBR, $urandom_range(hi, start), $urandom_range(16383),
                     $urandom_range(1023), $urandom_range(63));
        end
        repeat ($urandom_range(3, 1))
          send_txn(OP_SAMPLE, $urandom_range(8191), $urandom_range(16383), n,
                   pick_capacity());
        built_nodes.push_back(n);
        issued += 4;
      end else if (pick < 75) begin
        // revisit an earlier node; the generator has moved on
        if (built_nodes.size() > 0) begin
          n = built_nodes[$urandom_range(built_nodes.size() - 1)];
          if (node_ready(n)) begin
            send_txn(OP_SAMPLE, $urandom_range(8191), $urandom_range(16383), n,
                     pick_capacity());
            issued++;
          end
        end
      end else if (pick < 85) begin
        send_txn(OP_WR_NBR, $urandom_range(8191), $urandom_range(16383),
                 $urandom_range(1023), $urandom_range(63));
        issued++;
      end else if (pick < 92) begin
        // stray offset writes, some past the table
        if ($urandom_range(1)) begin
          send_txn(OP_WR_OFF, $urandom_range(8191, OFF_ENTRIES), $urandom_range(16383),
                   $urandom_range(1023), $urandom_range(63));
        end else begin
          send_txn(OP_WR_OFF, $urandom_range(OFF_ENTRIES - 1), $urandom_range(16383),
                   $urandom_range(1023), $urandom_range(63));
          issued++;
        end
      end else if (pick < 96) begin
        send_txn(OP_UNUSED, $urandom_range(8191), $urandom_range(16383),
                 $urandom_range(1023), $urandom_range(63));
      end else begin
        n = $urandom_range(1023);
        if (node_ready(n)) begin
          send_txn(OP_SAMPLE, $urandom_range(8191), $urandom_range(16383), n,
                   pick_capacity());
          issued++;
        end
      end
    end
  endtask

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both preloaded edge regions
    for (i = 0; i < LOW_REGION; i++)
      send_txn(OP_WR_NBR, i, $urandom_range(16383), $urandom_range(1023), $urandom_range(63));
    for (i = TOP_REGION; i < EDGE_ENTRIES; i++)
      send_txn(OP_WR_NBR, i, $urandom_range(16383), $urandom_range(1023), $urandom_range(63));

    // directed: short, long, empty and inverted lists at reset fanout
    send_txn(OP_WR_OFF, 0, 0, 0, 0);
    send_txn(OP_WR_OFF, 1, 4, 1023, 63);
    send_txn(OP_WR_OFF, 2, 40, 0, 0);
    send_txn(OP_WR_OFF, 3, 40, 0, 0);
    send_txn(OP_WR_OFF, 4, 20, 0, 0);
    send_txn(OP_WR_NBR, 0, 0, 0, 0);
    send_txn(OP_WR_NBR, 3, 16383, 1023, 63);
    send_txn(OP_SAMPLE, 0, 0, 0, 63);
    send_txn(OP_SAMPLE, 8191, 16383, 0, 2);
    send_txn(OP_SAMPLE, 0, 0, 0, 0);
    send_txn(OP_SAMPLE, 0, 0, 1, 32);
    send_txn(OP_SAMPLE, 0, 0, 1, 3);
    send_txn(OP_SAMPLE, 0, 0, 2, 32);
    send_txn(OP_SAMPLE, 0, 0, 3, 32);
    // last node, list running off the edge table
    send_txn(OP_WR_OFF, 1023, 8180, 0, 0);
    send_txn(OP_WR_OFF, 1024, 8200, 0, 0);
    send_txn(OP_SAMPLE, 0, 0, 1023, 32);
    // writes past the offset table are dropped
    send_txn(OP_WR_OFF, 8191, 16383, 1023, 63);
    send_txn(OP_WR_OFF, 1025, 5, 0, 0);
    send_txn(OP_UNUSED, 8191, 16383, 1023, 63);
    send_txn(OP_SAMPLE, 0, 0, 1, 1);
    send_txn(OP_WR_NBR, 8191, 8192, 0, 0);
    send_txn(OP_SAMPLE, 0, 0, 1023, 63);

    run_traffic(12);
    await_drain();

    send_gap = 51;
    recv_gap = 35;
    load_regs(0, 32'd0);
    run_traffic(5);
    await_drain();
    load_regs(63, 32'hFFFF_FFFF);
    run_traffic(8);
    await_drain();
    load_regs(1, $urandom);
    run_traffic(5);
    await_drain();

    send_gap = 0;
    recv_gap = 0;
    load_regs(32, 32'd1);
    run_traffic(8);
    await_drain();
    load_regs($urandom_range(32, 1), $urandom);
    run_traffic(7);
    await_drain();

    @(negedge clk);
    if (mismatches == 0 && due_count == 0) begin
      $display("PASS graph_neighbor_sampler");
    end else begin
      $display("FAIL graph_neighbor_sampler");
    end
    $finish;
  end

endmodule
